// ===== design/pu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_pkg: shared definitions for the permutation unranking block
// Field widths, the factorial table, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pu_pkg;

  localparam int MAX_SIZE = 20;   // largest supported permutation size
  localparam int RANK_W   = 62;   // width of the rank field
  localparam int SIZE_W   = 5;    // width of the size register
  localparam int ELEM_W   = 5;    // width of one element and one digit
  localparam int STEP_W   = $clog2(ELEM_W);  // counts quotient bits of a digit
  localparam int TRIAL_W  = RANK_W + ELEM_W; // a factorial shifted by a digit bit

  localparam logic [SIZE_W-1:0] PERM_SIZE_RST = SIZE_W'(20);

  // Factorials 0! through 20!; entry n is n!.
  localparam logic [RANK_W-1:0] FACT [0:MAX_SIZE] = '{
    62'd1,
    62'd1,
    62'd2,
    62'd6,
    62'd24,
    62'd120,
    62'd720,
    62'd5040,
    62'd40320,
    62'd362880,
    62'd3628800,
    62'd39916800,
    62'd479001600,
    62'd6227020800,
    62'd87178291200,
    62'd1307674368000,
    62'd20922789888000,
    62'd355687428096000,
    62'd6402373705728000,
    62'd121645100408832000,
    62'd2432902008176640000
  };

  typedef enum logic [2:0] {
    PU_IDLE,
    PU_CHECK,
    PU_DIV,
    PU_PICK,
    PU_OOR
  } pu_state_t;

  typedef struct packed {
    logic load;      // take a new rank and the current size
    logic div_step;  // one quotient bit of the current digit
    logic pick;      // select the value for the digit and emit it
    logic emit_oor;  // emit the single out-of-range word
  } pu_cmd_t;

  typedef struct packed {
    logic oor;       // rank is not below n!
    logic div_done;  // the last quotient bit of the digit is being made
    logic pos_last;  // the current position is the final one
    logic out_free;  // the output register can take a word this cycle
  } pu_stat_t;

endpackage

// ===== design/pu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_if: channel interfaces of the permutation unranking block
// Rank input, element output and size configuration, each a valid/ready
// channel with a source and a sink side.
// ----------------------------------------------------------------------------
interface pu_rank_if import pu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

interface pu_elem_if import pu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic              last;
  logic              out_of_range;

  modport source (output valid, output element, output last, output out_of_range,
                  input ready);
  modport sink   (input valid, input element, input last, input out_of_range,
                  output ready);
endinterface

interface pu_cfg_if import pu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] perm_size;

  modport source (output valid, output perm_size, input ready);
  modport sink   (input valid, input perm_size, output ready);
endinterface

// ===== design/permutation_unrank_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_unrank_top: factoradic permutation unranking
// Takes a rank k and emits the k-th lexicographic permutation of 0..n-1,
// one element per word, with the final word marked.
// ----------------------------------------------------------------------------
//
//   Channel   Side   Word contents
//   -------   ----   ----------------------------------------------
//   rank_ch   sink   rank (62 bits)
//   perm_ch   source element (5 bits), last, out_of_range
//   cfg_ch    sink   perm_size (5 bits), always ready
//
// One rank is handled at a time. After the accept cycle the range check runs;
// each position then takes a five-bit restoring division against a factorial
// (one quotient bit per cycle) and then a selection step. An out-of-range
// rank goes from the range check straight to a single flagged word. A stalled
// output holds the machine in the selection step or the out-of-range step.
// Reset is synchronous and sets the size to 20; no memory clearing is
// needed.
//
module permutation_unrank_top import pu_pkg::*; #(
  parameter int MaxSize = MAX_SIZE
) (
  input logic         clk,
  input logic         rst,
  pu_rank_if.sink     rank_ch,
  pu_elem_if.source   perm_ch,
  pu_cfg_if.sink      cfg_ch
);

  pu_cmd_t  cmd;
  pu_stat_t stat;

  // The size register is a plain flop, so configuration words are always taken.
  assign cfg_ch.ready = 1'b1;

  // The controller decides when a rank is taken and which datapath step runs.
  pu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rank_ch.valid),
    .in_ready (rank_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath turns the rank into digits most significant first, dividing
  // the remainder by (n-1-i)! for position i, and picks each element at once.
  pu_dp #(
    .MaxSize (MaxSize)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .rank        (rank_ch.rank),
    .cfg_we      (cfg_ch.valid),
    .cfg_size    (cfg_ch.perm_size),
    .out_valid   (perm_ch.valid),
    .out_ready   (perm_ch.ready),
    .out_element (perm_ch.element),
    .out_last    (perm_ch.last),
    .out_oor     (perm_ch.out_of_range)
  );

endmodule

// ===== design/pu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_ctrl: sequencing state machine
// Steps the datapath through range check, digit extraction and selection.
// ----------------------------------------------------------------------------
module pu_ctrl import pu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pu_stat_t stat,
  output pu_cmd_t  cmd
);

  pu_state_t state;
  pu_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      PU_IDLE: begin
        if (in_valid) state_next = PU_CHECK;
      end
      PU_CHECK: begin
        state_next = stat.oor ? PU_OOR : PU_DIV;
      end
      PU_DIV: begin
        if (stat.div_done) state_next = PU_PICK;
      end
      PU_PICK: begin
        if (stat.out_free) state_next = stat.pos_last ? PU_IDLE : PU_DIV;
      end
      PU_OOR: begin
        if (stat.out_free) state_next = PU_IDLE;
      end
      default: state_next = PU_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == PU_IDLE);
    cmd.load     = (state == PU_IDLE) && in_valid;
    cmd.div_step = (state == PU_DIV);
    cmd.pick     = (state == PU_PICK) && stat.out_free;
    cmd.emit_oor = (state == PU_OOR) && stat.out_free;
  end

endmodule

// ===== design/pu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_dp: unranking datapath
// Holds the size register, the running remainder, the digit being built,
// the mask of unused values and the output register.
// ----------------------------------------------------------------------------
module pu_dp import pu_pkg::*; #(
  parameter int MaxSize = MAX_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  pu_cmd_t           cmd,
  output pu_stat_t          stat,
  input  logic [RANK_W-1:0] rank,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ELEM_W-1:0] out_element,
  output logic              out_last,
  output logic              out_oor
);

  logic [SIZE_W-1:0]  perm_size;
  logic [SIZE_W-1:0]  n_eff;
  logic [SIZE_W-1:0]  size_clamped;
  logic [RANK_W-1:0]  rem;
  logic [SIZE_W-1:0]  pos;
  logic [STEP_W-1:0]  bit_idx;
  logic [ELEM_W-1:0]  digit;
  logic [MaxSize-1:0] mask;
  logic [MaxSize-1:0] mask_init;
  logic [MaxSize-1:0] hit;
  logic [ELEM_W-1:0]  sel;
  logic [RANK_W-1:0]  fact_pos;
  logic [TRIAL_W-1:0] trial;
  logic               fits;

  // A size of zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    priority if (perm_size == '0) begin
      size_clamped = SIZE_W'(1);
    end else if (perm_size > SIZE_W'(MaxSize)) begin
      size_clamped = SIZE_W'(MaxSize);
    end else begin
      size_clamped = perm_size;
    end
  end

  always_comb begin
    for (int v = 0; v < MaxSize; v++) begin
      mask_init[v] = (SIZE_W'(v) < size_clamped);
    end
  end

  // Factorial of the number of positions after the current one.
  assign fact_pos = FACT[n_eff - pos - SIZE_W'(1)];
  assign trial    = {{ELEM_W{1'b0}}, fact_pos} << bit_idx;
  assign fits     = ({{ELEM_W{1'b0}}, rem} >= trial);

  // Value v is picked when it is unused and exactly digit unused values lie below it.
  always_comb begin
    logic [MaxSize-1:0] below;
    sel = '0;
    for (int v = 0; v < MaxSize; v++) begin
      below  = mask & ((MaxSize'(1) << v) - MaxSize'(1));
      hit[v] = mask[v] && (ELEM_W'($countones(below)) == digit);
      if (hit[v]) sel = sel | ELEM_W'(v);
    end
  end

  always_comb begin
    stat.oor      = (rem >= FACT[n_eff]);
    stat.div_done = (bit_idx == '0);
    stat.pos_last = (pos == n_eff - SIZE_W'(1));
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size <= PERM_SIZE_RST;
    end else if (cfg_we) begin
      perm_size <= cfg_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem     <= rank;
      n_eff   <= size_clamped;
      mask    <= mask_init;
      pos     <= '0;
      digit   <= '0;
      bit_idx <= STEP_W'(ELEM_W - 1);
    end else if (cmd.div_step) begin
      if (fits) begin
        rem          <= rem - trial[RANK_W-1:0];
        digit[bit_idx] <= 1'b1;
      end
      bit_idx <= bit_idx - STEP_W'(1);
    end else if (cmd.pick) begin
      mask    <= mask & ~hit;
      pos     <= pos + SIZE_W'(1);
      digit   <= '0;
      bit_idx <= STEP_W'(ELEM_W - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pick || cmd.emit_oor) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      out_element <= sel;
      out_last    <= stat.pos_last;
      out_oor     <= 1'b0;
    end else if (cmd.emit_oor) begin
      out_element <= '0;
      out_last    <= 1'b1;
      out_oor     <= 1'b1;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for permutation_unrank_top
// Sends ranks at several permutation sizes and predicts each element word.
// Every accepted element word is checked against the oldest expected word.
// Both channels idle at random, and the output stalls for one long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import pu_pkg::*;

  // The size register comes out of reset at 20.
  localparam int SIZE_AT_RESET = 20;
  // This many cycles with no accepted word on any channel ends the run. The
  // longest legal quiet stretch is the long output stall below.
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_STALL    = 400;
  // Wait at the end for longer than one unstalled rank at the largest size
  // takes, to catch any stray word.
  localparam int TAIL_CYCLES   = 130;
  localparam int RANKS_PER_SIZE = 49;

  // One element word as it leaves the block.
  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              last;
    logic              out_of_range;
  } perm_word_t;

  // Keeps its own copy of the size register and the words still to come.
  class perm_scoreboard;
    logic [SIZE_W-1:0] size_reg;
    perm_word_t        pending_words[$];
    int unsigned       errors;

    function new();
      size_reg = SIZE_W'(SIZE_AT_RESET);
      errors   = 0;
    endfunction

    // A size of zero acts as one, and sizes past the maximum saturate.
    function int unsigned eff_size(logic [SIZE_W-1:0] s);
      int unsigned n;
      n = s;
      if (n == 0) begin
        n = 1;
      end
      if (n > MAX_SIZE) begin
        n = MAX_SIZE;
      end
      return n;
    endfunction

    function logic [63:0] factorial(int unsigned n);
      logic [63:0] f;
      f = 64'd1;
      for (int unsigned j = 2; j <= n; j++) begin
        f = f * j;
      end
      return f;
    endfunction

    // Unranks one accepted rank into the words the block should send.
    function void note_rank(logic [RANK_W-1:0] rank);
      int unsigned          n;
      int unsigned          seen;
      int unsigned          chosen;
      logic [63:0]          quot;
      logic [ELEM_W-1:0]    digit [MAX_SIZE];
      logic [MAX_SIZE-1:0]  remaining;
      perm_word_t           w;
      n = eff_size(size_reg);
      if ({2'b00, rank} >= factorial(n)) begin
        // A rank past n! gives a single flagged word and nothing else.
        w.element      = '0;
        w.last         = 1'b1;
        w.out_of_range = 1'b1;
        pending_words.insert(pending_words.size(), w);
        return;
      end
      // Remainder of the division by j is the digit of position n - j.
      quot = rank;
      for (int unsigned j = 1; j <= n; j++) begin
        digit[n-j] = ELEM_W'(quot % j);
        quot       = quot / j;
      end
      // Each digit picks the d-th value still unused, counted from the bottom.
      remaining = MAX_SIZE'((64'd1 << n) - 64'd1);
      for (int unsigned i = 0; i < n; i++) begin
        seen   = 0;
        chosen = 0;
        for (int unsigned v = 0; v < MAX_SIZE; v++) begin
          if (remaining[v]) begin
            if (seen == digit[i]) begin
              chosen = v;
            end
            seen++;
          end
        end
        remaining[chosen] = 1'b0;
        w.element         = ELEM_W'(chosen);
        w.last            = (i == n - 1);
        w.out_of_range    = 1'b0;
        pending_words.insert(pending_words.size(), w);
      end
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_word(perm_word_t got);
      perm_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("element word %0d with nothing expected", got.element));
        return;
      end
      want = pending_words.pop_front();
      if (got.element !== want.element) begin
        report($sformatf("element %0d, expected %0d", got.element, want.element));
      end
      if (got.last !== want.last) begin
        report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
      if (got.out_of_range !== want.out_of_range) begin
        report($sformatf("out_of_range %0b, expected %0b",
                         got.out_of_range, want.out_of_range));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  pu_rank_if rank_ch ();
  pu_elem_if perm_ch ();
  pu_cfg_if  cfg_ch ();

  permutation_unrank_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .rank_ch (rank_ch),
    .perm_ch (perm_ch),
    .cfg_ch  (cfg_ch)
  );

  perm_scoreboard sb = new();

  // Size that the stimulus is shaped for; it follows each register write.
  logic [SIZE_W-1:0] stim_size = SIZE_W'(SIZE_AT_RESET);
  // Set by the stimulus to ask the output side for one long stall.
  bit                hold_req  = 1'b0;
  int unsigned       quiet_cycles = 0;
  perm_word_t        seen_word;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitors sample the channels at the rising edge, before any new values
  // driven at that edge take effect, so there is no ordering race.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.size_reg = cfg_ch.perm_size;
      end
      if (rank_ch.valid && rank_ch.ready) begin
        sb.note_rank(rank_ch.rank);
      end
      if (perm_ch.valid && perm_ch.ready) begin
        seen_word.element      = perm_ch.element;
        seen_word.last         = perm_ch.last;
        seen_word.out_of_range = perm_ch.out_of_range;
        sb.check_word(seen_word);
      end
    end
  end

  // Watchdog: a hung handshake anywhere shows up as a long quiet stretch.
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (rank_ch.valid && rank_ch.ready)
        || (perm_ch.valid && perm_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Output side. The stall pattern switches every so often between always
  // ready, a coin toss, mostly stalled and a fixed on/off rhythm. When the
  // stimulus asks for it, ready stays low for a long stretch so that the
  // block backs up and stops taking ranks.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    perm_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        perm_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: begin
            perm_ch.ready <= 1'b1;
          end
          1: begin
            perm_ch.ready <= $urandom_range(0, 1);
          end
          2: begin
            perm_ch.ready <= ($urandom_range(0, 4) == 0);
          end
          default: begin
            perm_ch.ready <= ((tick % 5) < 3);
          end
        endcase
      end
    end
  end

  // Offers one rank and returns at the edge where it is taken. Valid stays
  // high on return so back-to-back ranks need no extra cycle.
  task send_rank(input logic [RANK_W-1:0] r);
    rank_ch.rank  <= r;
    rank_ch.valid <= 1'b1;
    do @(posedge clk); while (!rank_ch.ready);
  endtask

  // Lowers valid and waits until every predicted word has come back.
  task drain_block();
    rank_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  task write_size(input logic [SIZE_W-1:0] s);
    cfg_ch.perm_size <= s;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    stim_size = s;
  endtask

  // Mostly ranks inside 0..n!-1, with the bounds and some ranks at or past n!
  // mixed in. Full-width random ranks make every rank bit toggle even at
  // small sizes, where they all fall out of range.
  function logic [RANK_W-1:0] pick_rank();
    int unsigned n;
    int unsigned sel;
    logic [63:0] fact;
    logic [63:0] wide;
    n    = sb.eff_size(stim_size);
    fact = sb.factorial(n);
    wide = {$urandom, $urandom};
    sel  = $urandom_range(0, 99);
    if (sel < 70) begin
      return RANK_W'(wide % fact);
    end else if (sel < 77) begin
      return RANK_W'(fact - 64'd1);
    end else if (sel < 82) begin
      return '0;
    end else if (sel < 90) begin
      return RANK_W'(fact + $urandom_range(0, 3));
    end
    return wide[RANK_W-1:0];
  endfunction

  // Ranks go out in bursts of random length. Some bursts are long and
  // some gaps are zero, so there are stretches with no idling at all.
  task send_random_ranks(input int unsigned count);
    int unsigned burst;
    int unsigned gap;
    burst = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          rank_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      send_rank(pick_rank());
    end
  endtask

  // Ranks at the reset size of 20: the first two permutations and the last,
  // the first rank past the end, the all-ones rank, and a few ranks that
  // land on large factorial digits.
  localparam logic [RANK_W-1:0] EDGE_RANKS [8] = '{
    62'd0,
    62'd1,
    62'd2432902008176639999,
    62'd2432902008176640000,
    {RANK_W{1'b1}},
    62'd121645100408832000,
    62'd1216451004088320000,
    62'd2305843009213693952
  };

  // Size plan: both ends of the legal range, zero (acts as one), values past
  // the maximum (act as 20) and some sizes in between. A final size after the
  // plan is drawn at random.
  localparam logic [SIZE_W-1:0] SIZE_PLAN [9] = '{
    5'd1, 5'd20, 5'd0, 5'd31, 5'd2, 5'd7, 5'd13, 5'd21, 5'd5
  };

  initial begin
    rst              = 1'b1;
    rank_ch.valid    = 1'b0;
    rank_ch.rank     = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.perm_size = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed ranks first, at the size the register takes from reset.
    foreach (EDGE_RANKS[k]) begin
      send_rank(EDGE_RANKS[k]);
    end
    drain_block();

    // The register is only written once the block has gone quiet.
    foreach (SIZE_PLAN[p]) begin
      write_size(SIZE_PLAN[p]);
      // The long output stall goes in the phase with the slowest ranks.
      if (SIZE_PLAN[p] == 5'd20) begin
        hold_req = 1'b1;
      end
      send_random_ranks(RANKS_PER_SIZE);
      drain_block();
    end
    write_size(SIZE_W'($urandom_range(1, MAX_SIZE)));
    send_random_ranks(RANKS_PER_SIZE);
    drain_block();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== permutation_unrank_top.f =====
design/pu_pkg.sv
design/pu_if.sv
design/pu_ctrl.sv
design/pu_dp.sv
design/permutation_unrank_top.sv
tb/testbench.sv
